@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AM_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (c)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define AM_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (c)) \
        else $error("assertion failed");

`endif

@@ rtl/mlpa_pkg.sv @@
package mlpa_pkg;

    localparam int INPUT_COUNT       = 35;
    localparam int LAYER_ONE_WIDTH   = 128;
    localparam int LAYER_TWO_WIDTH   = 64;
    localparam int LAYER_THREE_WIDTH = 32;
    localparam int PARAM_DEPTH       = 16384;
    localparam int HEAD_COUNT        = 5;

    localparam int PA_W  = $clog2(PARAM_DEPTH);
    localparam int PTR_W = 18;
    localparam int CNT_W = 9;
    localparam int HEAD_W = 3;

    localparam int MAX_AB = (LAYER_ONE_WIDTH > LAYER_TWO_WIDTH) ?
                            LAYER_ONE_WIDTH : LAYER_TWO_WIDTH;
    localparam int MAX_CD = (LAYER_THREE_WIDTH > INPUT_COUNT) ?
                            LAYER_THREE_WIDTH : INPUT_COUNT;
    localparam int BUF_DEPTH = (MAX_AB > MAX_CD) ? MAX_AB : MAX_CD;
    localparam int BUF_W  = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int FEAT_W = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;

    localparam logic [1:0] CMD_LOAD_PARAM   = 2'd0;
    localparam logic [1:0] CMD_LOAD_FEATURE = 2'd1;
    localparam logic [1:0] CMD_RUN          = 2'd2;

    localparam logic signed [63:0] ACT_MAX = 64'sd8388607;
    localparam logic signed [63:0] ACT_MIN = -64'sd8388608;

    typedef struct packed {
        logic [1:0]         command;
        logic [13:0]        address;
        logic signed [23:0] value;
    } t_in_word;

    typedef struct packed {
        logic [1:0] fwd_pick;
        logic [1:0] side_pick;
        logic [2:0] turn_pick;
        logic       fire_action;
        logic       use_action;
    } t_out_word;

    typedef struct packed {
        logic     valid;
        t_in_word word;
    } t_queue;

    function automatic int head_size(input logic [HEAD_W-1:0] h);
        int n;
        case (h)
            3'd0:    n = 3;
            3'd1:    n = 3;
            3'd2:    n = 5;
            default: n = 2;
        endcase
        return n;
    endfunction

endpackage

@@ rtl/mlpa_front.sv @@
module mlpa_front import mlpa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_in_word i_word,
    output logic     busy,
    output t_queue   o_q,
    input  logic     i_q_ready
);

    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W = $clog2(QUEUE_DEPTH);

    t_in_word                r_mem [QUEUE_DEPTH];
    logic [QP_W-1:0]         r_wp, r_rp;
    logic [QP_W:0]           r_count;
    logic                    push, pop;

    assign busy = (r_count == (QP_W + 1)'(QUEUE_DEPTH));
    // drop the unused command code here
    assign push = start && !busy &&
                  (i_word.command inside {CMD_LOAD_PARAM, CMD_LOAD_FEATURE, CMD_RUN});
    assign o_q.valid = (r_count != '0);
    assign o_q.word  = r_mem[r_rp];
    assign pop = o_q.valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_count <= r_count + (QP_W + 1)'(push) - (QP_W + 1)'(pop);
        end
    end

endmodule

@@ rtl/mlpa_engine.sv @@
module mlpa_engine import mlpa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_queue    i_q,
    output logic      o_q_ready,
    output logic      o_strobe,
    output t_out_word o_result
);

    typedef enum logic [2:0] {
        E_IDLE, E_NORM, E_L1, E_L2, E_L3, E_HEAD, E_DRAIN
    } t_state;

    typedef enum logic [1:0] { K_NORM, K_RELU, K_HEAD } t_kind;
    typedef enum logic [1:0] { S_FEAT, S_BUF_A, S_BUF_B } t_src;

    typedef struct packed {
        logic              bias;
        logic              last;
        logic              head_last;
        t_kind             kind;
        logic [CNT_W-1:0]  idx;
        logic [HEAD_W-1:0] head;
        logic              dest_b;
    } t_tag;

    logic signed [23:0] pmem [PARAM_DEPTH];
    logic signed [23:0] fmem [INPUT_COUNT];
    logic signed [23:0] amem [BUF_DEPTH];
    logic signed [23:0] bmem [BUF_DEPTH];

    t_state r_state, n_state, r_after, n_after;
    logic [CNT_W-1:0]  r_o, n_o, r_j, n_j;
    logic              r_bias, n_bias;
    logic [PTR_W-1:0]  r_wptr, n_wptr, r_bptr, n_bptr;
    logic [HEAD_W-1:0] r_head, n_head;
    logic              r_strobe, n_strobe;
    t_out_word         r_res, n_res;
    logic signed [63:0] r_best, n_best;
    logic [2:0]        r_best_idx, n_best_idx;

    logic              iss_valid;
    logic [PTR_W-1:0]  iss_paddr;
    logic [CNT_W-1:0]  iss_aaddr;
    t_tag              iss_tag;
    t_src              iss_src;
    logic [CNT_W-1:0]  cur_in, cur_out;

    logic signed [23:0] r_pd, r_fd, r_ad_a, r_ad_b;
    logic              r_m_valid, r_m_zero;
    t_tag              r_m_tag;
    t_src              r_m_src;
    logic              r_x_valid;
    t_tag              r_x_tag;
    logic signed [47:0] r_x_term;
    logic signed [63:0] r_acc;
    logic              r_w_valid;
    t_tag              r_w_tag;

    logic              ld_param, ld_feat;
    logic signed [23:0] adata;
    logic signed [47:0] term;
    logic signed [63:0] rounded, shifted;
    logic signed [23:0] act;
    logic              wr_a, wr_b, take;
    logic              empty;

    assign o_q_ready = (r_state == E_IDLE);
    assign ld_param = o_q_ready && i_q.valid && i_q.word.command == CMD_LOAD_PARAM &&
                      {4'd0, i_q.word.address} < PTR_W'(PARAM_DEPTH);
    assign ld_feat  = o_q_ready && i_q.valid && i_q.word.command == CMD_LOAD_FEATURE &&
                      {4'd0, i_q.word.address} < PTR_W'(INPUT_COUNT);
    assign empty = !r_m_valid && !r_x_valid && !r_w_valid;

    // writeback: round, saturate, rectify
    always_comb begin
        rounded = r_acc + 64'sd524288;
        shifted = rounded >>> 20;
        if (shifted > ACT_MAX)      act = ACT_MAX[23:0];
        else if (shifted < ACT_MIN) act = ACT_MIN[23:0];
        else                        act = shifted[23:0];
        if (r_w_tag.kind == K_RELU && r_acc <= 64'sd0) act = '0;
    end

    assign wr_a = r_w_valid && r_w_tag.kind != K_HEAD && !r_w_tag.dest_b;
    assign wr_b = r_w_valid && r_w_tag.kind != K_HEAD && r_w_tag.dest_b;
    assign take = (r_w_tag.idx == '0) || (r_acc > r_best);

    always_comb begin
        n_state = r_state;  n_after = r_after;
        n_o = r_o;  n_j = r_j;  n_bias = r_bias;
        n_wptr = r_wptr;  n_bptr = r_bptr;  n_head = r_head;
        n_strobe = 1'b0;  n_res = r_res;
        n_best = r_best;  n_best_idx = r_best_idx;
        iss_valid = 1'b0;  iss_paddr = '0;  iss_aaddr = '0;
        iss_tag = '0;  iss_src = S_FEAT;
        cur_in = CNT_W'(1);  cur_out = CNT_W'(1);

        unique case (r_state)
            E_NORM: begin cur_in = CNT_W'(1); cur_out = CNT_W'(INPUT_COUNT); end
            E_L1: begin cur_in = CNT_W'(INPUT_COUNT); cur_out = CNT_W'(LAYER_ONE_WIDTH); end
            E_L2: begin
                cur_in = CNT_W'(LAYER_ONE_WIDTH); cur_out = CNT_W'(LAYER_TWO_WIDTH);
            end
            E_L3: begin
                cur_in = CNT_W'(LAYER_TWO_WIDTH); cur_out = CNT_W'(LAYER_THREE_WIDTH);
            end
            E_HEAD: begin
                cur_in = CNT_W'(LAYER_THREE_WIDTH); cur_out = CNT_W'(head_size(r_head));
            end
            default: ;
        endcase

        unique case (r_state)
            E_IDLE: begin
                if (i_q.valid && i_q.word.command == CMD_RUN) begin
                    n_state = E_NORM;
                    n_o = '0;  n_j = '0;  n_bias = 1'b1;  n_head = '0;
                end
            end
            E_NORM, E_L1, E_L2, E_L3, E_HEAD: begin
                iss_valid = 1'b1;
                iss_tag.idx = r_o;
                iss_tag.head = r_head;
                iss_tag.kind = (r_state == E_NORM) ? K_NORM :
                               (r_state == E_HEAD) ? K_HEAD : K_RELU;
                iss_tag.dest_b = (r_state == E_L1) || (r_state == E_L3);
                unique case (r_state)
                    E_NORM:     iss_src = S_FEAT;
                    E_L2, E_HEAD: iss_src = S_BUF_B;
                    default:    iss_src = S_BUF_A;
                endcase
                if (r_bias) begin
                    iss_tag.bias = 1'b1;
                    n_bias = 1'b0;
                    if (r_state == E_NORM) begin
                        iss_paddr = PTR_W'({r_o, 1'b1});
                    end else begin
                        iss_paddr = r_bptr;
                        n_bptr = r_bptr + PTR_W'(1);
                    end
                end else begin
                    iss_tag.last = (r_j == cur_in - CNT_W'(1));
                    iss_tag.head_last = iss_tag.last && (r_state == E_HEAD) &&
                                        (r_o == cur_out - CNT_W'(1));
                    n_j = r_j + CNT_W'(1);
                    if (r_state == E_NORM) begin
                        iss_paddr = PTR_W'({r_o, 1'b0});
                        iss_aaddr = r_o;
                    end else begin
                        iss_paddr = r_wptr;
                        iss_aaddr = r_j;
                        n_wptr = r_wptr + PTR_W'(1);
                    end
                    if (iss_tag.last) begin
                        n_j = '0;
                        n_bias = 1'b1;
                        n_o = r_o + CNT_W'(1);
                        if (r_o == cur_out - CNT_W'(1)) begin
                            n_o = '0;
                            n_state = E_DRAIN;
                            // next layer starts just past this layer's biases
                            n_wptr = r_bptr;
                            unique case (r_state)
                                E_NORM: begin
                                    n_after = E_L1;
                                    n_wptr = PTR_W'(2 * INPUT_COUNT);
                                    n_bptr = PTR_W'(2 * INPUT_COUNT +
                                                    INPUT_COUNT * LAYER_ONE_WIDTH);
                                end
                                E_L1: begin
                                    n_after = E_L2;
                                    n_bptr = r_bptr +
                                             PTR_W'(LAYER_ONE_WIDTH * LAYER_TWO_WIDTH);
                                end
                                E_L2: begin
                                    n_after = E_L3;
                                    n_bptr = r_bptr +
                                             PTR_W'(LAYER_TWO_WIDTH * LAYER_THREE_WIDTH);
                                end
                                E_L3: begin
                                    n_after = E_HEAD;
                                    n_bptr = r_bptr + PTR_W'(LAYER_THREE_WIDTH *
                                                             head_size('0));
                                end
                                default: begin
                                    if (r_head == HEAD_W'(HEAD_COUNT - 1)) begin
                                        n_after = E_IDLE;
                                    end else begin
                                        // no head reads another head's result: go on without draining
                                        n_state = E_HEAD;
                                        n_head = r_head + HEAD_W'(1);
                                        n_bptr = r_bptr + PTR_W'(LAYER_THREE_WIDTH *
                                                 head_size(r_head + HEAD_W'(1)));
                                    end
                                end
                            endcase
                        end
                    end
                end
            end
            E_DRAIN: begin
                if (empty) begin
                    n_state = r_after;
                    n_o = '0;  n_j = '0;  n_bias = 1'b1;
                    if (r_after == E_IDLE) n_strobe = 1'b1;
                end
            end
            default: n_state = E_IDLE;
        endcase

        if (r_w_valid && r_w_tag.kind == K_HEAD) begin
            if (take) begin
                n_best = r_acc;
                n_best_idx = r_w_tag.idx[2:0];
            end
            if (r_w_tag.head_last) begin
                case (r_w_tag.head)
                    3'd0:    n_res.fwd_pick   = take ? r_w_tag.idx[1:0] : r_best_idx[1:0];
                    3'd1:    n_res.side_pick  = take ? r_w_tag.idx[1:0] : r_best_idx[1:0];
                    3'd2:    n_res.turn_pick  = take ? r_w_tag.idx[2:0] : r_best_idx;
                    3'd3:    n_res.fire_action = take ? r_w_tag.idx[0] : r_best_idx[0];
                    default: n_res.use_action  = take ? r_w_tag.idx[0] : r_best_idx[0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= E_IDLE;
            r_after  <= E_IDLE;
            r_strobe <= 1'b0;
            r_bias   <= 1'b1;
            r_o      <= '0;
            r_j      <= '0;
            r_head   <= '0;
            r_wptr   <= '0;
            r_bptr   <= '0;
        end else begin
            r_state  <= n_state;
            r_after  <= n_after;
            r_strobe <= n_strobe;
            r_bias   <= n_bias;
            r_o      <= n_o;
            r_j      <= n_j;
            r_head   <= n_head;
            r_wptr   <= n_wptr;
            r_bptr   <= n_bptr;
        end
        r_res      <= n_res;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
    end

    always_ff @(posedge i_clk) begin
        if (ld_param) pmem[i_q.word.address[PA_W-1:0]] <= i_q.word.value;
        r_pd <= pmem[iss_paddr[PA_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (ld_feat) fmem[i_q.word.address[FEAT_W-1:0]] <= i_q.word.value;
        r_fd <= fmem[iss_aaddr[FEAT_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (wr_a) amem[r_w_tag.idx[BUF_W-1:0]] <= act;
        r_ad_a <= amem[iss_aaddr[BUF_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (wr_b) bmem[r_w_tag.idx[BUF_W-1:0]] <= act;
        r_ad_b <= bmem[iss_aaddr[BUF_W-1:0]];
    end

    // multiply stage: bias terms scale by 2^12, offsets negate
    always_comb begin
        case (r_m_src)
            S_FEAT:  adata = r_fd;
            S_BUF_A: adata = r_ad_a;
            default: adata = r_ad_b;
        endcase
        if (r_m_zero) begin
            term = '0;
        end else if (r_m_tag.bias) begin
            term = 48'(r_pd) <<< 12;
            if (r_m_tag.kind == K_NORM) term = -term;
        end else begin
            term = r_pd * adata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_x_valid <= 1'b0;
            r_w_valid <= 1'b0;
        end else begin
            r_m_valid <= iss_valid;
            r_x_valid <= r_m_valid;
            r_w_valid <= r_x_valid && r_x_tag.last;
        end
        r_m_tag  <= iss_tag;
        r_m_src  <= iss_src;
        r_m_zero <= (iss_paddr >= PTR_W'(PARAM_DEPTH));
        r_x_tag  <= r_m_tag;
        r_x_term <= term;
        r_w_tag  <= r_x_tag;
        if (r_x_valid) begin
            r_acc <= r_x_tag.bias ? 64'(r_x_term) : r_acc + 64'(r_x_term);
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

@@ rtl/mlp_inference_argmax_heads_core.sv @@
// Multilayer perceptron inference with argmax heads. A word with a defined command
// is taken when start is high and busy is low; parameter and feature loads are
// written while the engine is idle, and a two-word queue lets the host issue up to
// two words while a run is in progress. A run streams one multiply-accumulate per
// cycle, except while the pipeline drains at each layer boundary, through a single
// MAC pipeline fed by the parameter memory read port: one bias slot plus one
// slot per input for every neuron. The five head classes are on o_result when
// o_done_strobe is high for a single cycle; the receiver cannot stall, so that
// result must be captured then.
`include "assert_macros.svh"
module mlp_inference_argmax_heads_core import mlpa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_word  i_word,
    output logic      busy,
    output logic      o_done_strobe,
    output t_out_word o_result
);

    t_queue q;
    logic   q_ready;

    mlpa_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_word    (i_word),
        .busy      (busy),
        .o_q       (q),
        .i_q_ready (q_ready)
    );

    mlpa_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q       (q),
        .o_q_ready (q_ready),
        .o_strobe  (o_done_strobe),
        .o_result  (o_result)
    );

    `AM_NEXT(a_strobe_single, i_clk, i_rst_n, o_done_strobe, !o_done_strobe)
    `AM_IMP(a_busy_has_word, i_clk, i_rst_n, busy, q.valid)
    `AM_IMP(a_strobe_after_run, i_clk, i_rst_n, o_done_strobe, !$past(q_ready))

endmodule
